>>> rtl/rbs_pkg.sv
// Package for the restart backoff supervisor: sizes, register indexes,
// reset values, controller states and the command/status structs.
// No dependencies.
package rbs_pkg;

  localparam int ENTRIES = 8;
  localparam int IDX_W   = $clog2(ENTRIES);

  localparam int CFG_ADDR_W = 4;

  localparam logic [7:0]  RESTART_LIMIT_RST = 8'd3;
  localparam logic [31:0] BACKOFF_BASE_RST  = 32'd100;
  localparam logic [31:0] BACKOFF_CAP_RST   = 32'd5000;

  typedef enum logic [1:0] {
    REG_ENABLED_MASK  = 2'd0,
    REG_RESTART_LIMIT = 2'd1,
    REG_BACKOFF_BASE  = 2'd2,
    REG_BACKOFF_CAP   = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FAULT,
    ST_ARM,
    ST_CHECK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [7:0]  enabled_mask;
    logic [7:0]  restart_limit;
    logic [31:0] backoff_base;
    logic [31:0] backoff_cap;
  } cfg_t;

  typedef struct packed {
    logic             load;
    logic             fault;
    logic             arm_step;
    logic             check_step;
    logic             finish;
    logic [IDX_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic fault_sched;
    logic out_busy;
  } dp_status_t;

  // Bit i of an eight-bit mask; entries from eight upward have no bit.
  function automatic logic bit8(logic [7:0] m, logic [IDX_W-1:0] i);
    logic [31:0] w;
    w = 32'(i);
    bit8 = (w < 32'd8) ? m[w[2:0]] : 1'b0;
  endfunction

endpackage

>>> rtl/restart_backoff_supervisor.sv
// Top level of the restart backoff supervisor: configuration registers
// behind the APB-style port, controller and datapath instances.
// Depends on rbs_pkg, rbs_ctrl and rbs_dp.
//
//   channel   handshake                  payload
//   config    psel/penable/pwrite/pready paddr, pwdata, prdata
//   input     in_valid / in_ready        action, entry_index, tick, refuse_mask
//   output    out_valid / out_ready      scheduled .. armed_flag
//
// A fault beat that schedules a restart steps through latch, update, a sweep
// over the entry table to find the earliest due tick, and result; a fault
// beat that schedules none skips the sweep, and a check beat steps through
// latch, sweep and result. The sweep takes one entry per cycle. Reset is
// synchronous and leaves every entry idle with the default registers. A new
// beat is accepted while a result waits; the block stalls only at the end of
// that next beat until the waiting result is taken.
module restart_backoff_supervisor (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rbs_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           action,
  input  logic [2:0]                     entry_index,
  input  logic [31:0]                    tick,
  input  logic [7:0]                     refuse_mask,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           scheduled,
  output logic                           killed_now,
  output logic [7:0]                     restart_mask,
  output logic [3:0]                     issued_count,
  output logic                           timer_start,
  output logic [31:0]                    timer_delay,
  output logic                           armed_flag
);
  import rbs_pkg::*;

  cfg_t       cfg;
  logic       wr_en;
  reg_idx_t   reg_idx;
  logic [7:0] init_mask;
  dp_cmd_t    cmd;
  dp_status_t status;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  // Entries whose enable bit rises in this write are reinitialized.
  assign init_mask = (wr_en && reg_idx == REG_ENABLED_MASK) ?
                     (pwdata[7:0] & ~cfg.enabled_mask) : 8'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enabled_mask  <= '0;
      cfg.restart_limit <= RESTART_LIMIT_RST;
      cfg.backoff_base  <= BACKOFF_BASE_RST;
      cfg.backoff_cap   <= BACKOFF_CAP_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ENABLED_MASK:  cfg.enabled_mask  <= pwdata[7:0];
        REG_RESTART_LIMIT: cfg.restart_limit <= pwdata[7:0];
        REG_BACKOFF_BASE:  cfg.backoff_base  <= pwdata;
        REG_BACKOFF_CAP:   cfg.backoff_cap   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ENABLED_MASK:  prdata = {24'd0, cfg.enabled_mask};
      REG_RESTART_LIMIT: prdata = {24'd0, cfg.restart_limit};
      REG_BACKOFF_BASE:  prdata = cfg.backoff_base;
      REG_BACKOFF_CAP:   prdata = cfg.backoff_cap;
      default:           prdata = 32'd0;
    endcase
  end

  rbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  rbs_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .init_mask    (init_mask),
    .cmd          (cmd),
    .status       (status),
    .action       (action),
    .entry_index  (entry_index),
    .tick         (tick),
    .refuse_mask  (refuse_mask),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .scheduled    (scheduled),
    .killed_now   (killed_now),
    .restart_mask (restart_mask),
    .issued_count (issued_count),
    .timer_start  (timer_start),
    .timer_delay  (timer_delay),
    .armed_flag   (armed_flag)
  );

endmodule

>>> rtl/rbs_ctrl.sv
// Controller for the restart backoff supervisor: sequences the fault
// update, the sweep over the entry table and the result hand-off.
// Depends on rbs_pkg.
module rbs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                action,
  output logic                in_ready,
  output rbs_pkg::dp_cmd_t    cmd,
  input  rbs_pkg::dp_status_t status
);
  import rbs_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] cnt;
  logic             last;

  assign last = (cnt == IDX_W'(ENTRIES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if ((state == ST_ARM || state == ST_CHECK) && !last) begin
        cnt <= cnt + IDX_W'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = action ? ST_CHECK : ST_FAULT;
        end
      end
      ST_FAULT: begin
        state_next = status.fault_sched ? ST_ARM : ST_DONE;
      end
      ST_ARM, ST_CHECK: begin
        if (last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.idx        = cnt;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_FAULT: cmd.fault = 1'b1;
      ST_ARM:   cmd.arm_step = 1'b1;
      ST_CHECK: cmd.check_step = 1'b1;
      ST_DONE:  cmd.finish = !status.out_busy;
      default: ;
    endcase
  end

endmodule

>>> rtl/rbs_dp.sv
// Datapath for the restart backoff supervisor: entry table, fault and
// check updates, earliest-due search and the result register.
// Depends on rbs_pkg.
module rbs_dp (
  input  logic                clk,
  input  logic                rst,
  input  rbs_pkg::cfg_t       cfg,
  input  logic [7:0]          init_mask,
  input  rbs_pkg::dp_cmd_t    cmd,
  output rbs_pkg::dp_status_t status,
  input  logic                action,
  input  logic [2:0]          entry_index,
  input  logic [31:0]         tick,
  input  logic [7:0]          refuse_mask,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                scheduled,
  output logic                killed_now,
  output logic [7:0]          restart_mask,
  output logic [3:0]          issued_count,
  output logic                timer_start,
  output logic [31:0]         timer_delay,
  output logic                armed_flag
);
  import rbs_pkg::*;

  logic              pending [ENTRIES];
  logic              killed [ENTRIES];
  logic [31:0]       due_tick [ENTRIES];
  logic [31:0]       backoff [ENTRIES];
  logic [7:0]        restarts_done [ENTRIES];
  logic              armed;

  logic [2:0]        idx_q;
  logic [31:0]       tick_q;
  logic [7:0]        refuse_q;
  logic              do_arm;
  logic              sched_q;
  logic              kill_q;
  logic [7:0]        rmask_q;
  logic [3:0]        issued_q;
  logic              have;
  logic [31:0]       earliest;

  logic [IDX_W-1:0]  f_idx;
  logic              f_ok;
  logic              f_kill;
  logic              f_sched;
  logic [IDX_W-1:0]  rd;
  logic [31:0]       resched_due;
  logic [IDX_W-1:0]  c;
  logic              live_pre;
  logic              due_hit;
  logic              refused;
  logic              restart;
  logic [32:0]       dbl;
  logic [31:0]       new_backoff;
  logic              pend_post;
  logic [31:0]       due_post;
  logic              live_post;
  logic              take_min;
  logic [31:0]       delay;

  // Fault decision for the latched entry.
  assign f_idx   = IDX_W'(idx_q);
  assign f_ok    = (32'(idx_q) < ENTRIES) && bit8(cfg.enabled_mask, f_idx) && !killed[f_idx];
  assign f_kill  = f_ok && (restarts_done[f_idx] >= cfg.restart_limit);
  assign f_sched = f_ok && !f_kill;

  // One shared adder for new due ticks; the fault and the sweep never overlap.
  assign rd          = cmd.fault ? f_idx : cmd.idx;
  assign resched_due = tick_q + backoff[rd];

  // Sweep step for entry c.
  assign c        = cmd.idx;
  assign live_pre = bit8(cfg.enabled_mask, c) && pending[c] && !killed[c];
  assign due_hit  = cmd.check_step && live_pre && !(tick_q < due_tick[c]);
  assign refused  = due_hit && bit8(refuse_q, c);
  assign restart  = due_hit && !refused;
  assign dbl      = {backoff[c], 1'b0};
  assign new_backoff = (dbl > {1'b0, cfg.backoff_cap}) ? cfg.backoff_cap : dbl[31:0];

  // The earliest-due search sees the entry as it stands after this step.
  assign pend_post = pending[c] && !restart;
  assign due_post  = refused ? resched_due : due_tick[c];
  assign live_post = bit8(cfg.enabled_mask, c) && pend_post && !killed[c];
  assign take_min  = (cmd.arm_step || cmd.check_step) && live_post &&
                     (!have || (due_post < earliest));

  assign delay = (earliest > tick_q) ? (earliest - tick_q) : 32'd1;

  assign status.fault_sched = f_sched;
  assign status.out_busy    = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        pending[i]       <= 1'b0;
        killed[i]        <= 1'b0;
        due_tick[i]      <= '0;
        backoff[i]       <= BACKOFF_BASE_RST;
        restarts_done[i] <= '0;
      end
    end else begin
      // Newly enabled entries start over with the current base backoff.
      for (int i = 0; i < ENTRIES; i++) begin
        if (bit8(init_mask, IDX_W'(i))) begin
          pending[i]       <= 1'b0;
          killed[i]        <= 1'b0;
          due_tick[i]      <= '0;
          backoff[i]       <= cfg.backoff_base;
          restarts_done[i] <= '0;
        end
      end
      if (cmd.fault && f_kill) begin
        killed[f_idx]  <= 1'b1;
        pending[f_idx] <= 1'b0;
      end
      if (cmd.fault && f_sched) begin
        pending[f_idx]  <= 1'b1;
        due_tick[f_idx] <= resched_due;
      end
      if (refused) begin
        due_tick[c] <= resched_due;
      end
      if (restart) begin
        pending[c] <= 1'b0;
        backoff[c] <= new_backoff;
        if (restarts_done[c] != 8'hFF) begin
          restarts_done[c] <= restarts_done[c] + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed     <= 1'b0;
      out_valid <= 1'b0;
      do_arm    <= 1'b0;
      sched_q   <= 1'b0;
      kill_q    <= 1'b0;
      rmask_q   <= '0;
      issued_q  <= '0;
      have      <= 1'b0;
    end else begin
      if (cmd.load) begin
        do_arm   <= action;
        sched_q  <= 1'b0;
        kill_q   <= 1'b0;
        rmask_q  <= '0;
        issued_q <= '0;
        have     <= 1'b0;
      end
      if (cmd.fault) begin
        sched_q <= f_sched;
        kill_q  <= f_kill;
        if (f_sched) begin
          do_arm <= 1'b1;
        end
      end
      if (restart) begin
        rmask_q  <= rmask_q | (8'd1 << c);
        issued_q <= issued_q + 4'd1;
      end
      if (take_min) begin
        have <= 1'b1;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
        if (do_arm) begin
          armed <= have;
        end
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_q    <= entry_index;
      tick_q   <= tick;
      refuse_q <= refuse_mask;
    end
    if (take_min) begin
      earliest <= due_post;
    end
    if (cmd.finish) begin
      scheduled    <= sched_q;
      killed_now   <= kill_q;
      restart_mask <= rmask_q;
      issued_count <= issued_q;
      if (do_arm) begin
        timer_start <= have;
        timer_delay <= have ? delay : 32'd0;
        armed_flag  <= have;
      end else begin
        timer_start <= 1'b0;
        timer_delay <= 32'd0;
        armed_flag  <= armed;
      end
    end
  end

endmodule
